@@ rtl/utd_pkg.sv @@
`timescale 1ns / 1ps

package utd_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic ENC_UTF8    = 1'b0;
  localparam logic ENC_UTF16LE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CONT  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_ODD_LEN   = 3'd5;
  localparam logic [2:0] ST_UNPAIRED  = 3'd6;

  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] SURR_HI_MIN  = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN  = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX  = 16'hDFFF;

  // Results caused by one byte: up to two units, then an optional status item.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic [1:0]  n_units;
    logic        is_eob;
    logic [2:0]  status;
  } rec_t;

endpackage

@@ rtl/utd_in_if.sv @@
`timescale 1ns / 1ps

interface utd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

@@ rtl/utd_out_if.sv @@
`timescale 1ns / 1ps

interface utd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        last;
  logic [2:0]  status;

  modport source (output valid, output code_unit, output unit_valid, output last,
                  output status, input ready);
  modport sink (input valid, input code_unit, input unit_valid, input last,
                input status, output ready);
endinterface

@@ rtl/utd_front.sv @@
`timescale 1ns / 1ps

module utd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          take_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_buffer_i,
  output logic          push_o,
  output utd_pkg::rec_t rec_o
);

  logic        enc_q;
  logic        done_q, done_d;
  logic [2:0]  err_q, err_d;
  logic [1:0]  rem_q, rem_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;
  logic        par_q, par_d;
  logic [7:0]  held_q, held_d;
  logic        pend_q, pend_d;

  logic        active;
  logic [20:0] acc_new;
  logic [1:0]  rem_dec;
  logic        bad;
  logic [20:0] v_supp;
  logic [15:0] unit16;
  logic        is_high;
  logic        is_low;
  logic [2:0]  st;
  utd_pkg::rec_t rec;

  always_comb begin
    done_d  = done_q;
    err_d   = err_q;
    rem_d   = rem_q;
    len_d   = len_q;
    acc_d   = acc_q;
    par_d   = par_q;
    held_d  = held_q;
    pend_d  = pend_q;
    rec     = '0;
    st      = utd_pkg::ST_OK;
    active  = !done_q && (err_q == utd_pkg::ST_OK);
    acc_new = {acc_q[14:0], data_byte_i[5:0]};
    rem_dec = rem_q - 2'd1;
    v_supp  = acc_new - utd_pkg::CP_SUPP_BASE;
    bad     = ((len_q == 3'd2) && (acc_new < 21'h80)) ||
              ((len_q == 3'd3) && (acc_new < 21'h800)) ||
              ((len_q == 3'd4) && (acc_new < utd_pkg::CP_SUPP_BASE)) ||
              (acc_new > utd_pkg::CP_MAX) ||
              ((acc_new >= {5'd0, utd_pkg::SURR_HI_MIN}) &&
               (acc_new <= {5'd0, utd_pkg::SURR_LO_MAX}));
    unit16  = {data_byte_i, held_q};
    is_high = (unit16 >= utd_pkg::SURR_HI_MIN) && (unit16 <= utd_pkg::SURR_HI_MAX);
    is_low  = (unit16 >= utd_pkg::SURR_LO_MIN) && (unit16 <= utd_pkg::SURR_LO_MAX);

    if (take_i) begin
      if (enc_q == utd_pkg::ENC_UTF8) begin
        if (active) begin
          if (rem_q == 2'd0) begin
            if (data_byte_i == 8'h00) begin
              done_d = 1'b1;
            end else if (!data_byte_i[7]) begin
              rec.unit0   = {8'h00, data_byte_i};
              rec.n_units = 2'd1;
            end else if (data_byte_i[7:5] == 3'b110) begin
              len_d = 3'd2;
              rem_d = 2'd1;
              acc_d = {16'd0, data_byte_i[4:0]};
            end else if (data_byte_i[7:4] == 4'b1110) begin
              len_d = 3'd3;
              rem_d = 2'd2;
              acc_d = {17'd0, data_byte_i[3:0]};
            end else if (data_byte_i[7:3] == 5'b11110) begin
              len_d = 3'd4;
              rem_d = 2'd3;
              acc_d = {18'd0, data_byte_i[2:0]};
            end else begin
              err_d = utd_pkg::ST_BAD_LEAD;
            end
          end else if (data_byte_i[7:6] != 2'b10) begin
            err_d = utd_pkg::ST_BAD_CONT;
          end else begin
            acc_d = acc_new;
            rem_d = rem_dec;
            if (rem_dec == 2'd0) begin
              if (bad) begin
                err_d = utd_pkg::ST_RANGE;
              end else if (acc_new[20:16] == 5'd0) begin
                rec.unit0   = acc_new[15:0];
                rec.n_units = 2'd1;
              end else begin
                rec.unit0   = {6'b110110, v_supp[19:10]};
                rec.unit1   = {6'b110111, v_supp[9:0]};
                rec.n_units = 2'd2;
              end
              acc_d = '0;
              len_d = '0;
            end
          end
        end
      end else if (!par_q) begin
        held_d = data_byte_i;
        par_d  = 1'b1;
      end else begin
        par_d = 1'b0;
        if (active) begin
          if (pend_q) begin
            if (is_low) begin
              rec.unit0   = unit16;
              rec.n_units = 2'd1;
              pend_d      = 1'b0;
            end else begin
              err_d = utd_pkg::ST_UNPAIRED;
            end
          end else if (unit16 == 16'h0000) begin
            done_d = 1'b1;
          end else if (is_high) begin
            rec.unit0   = unit16;
            rec.n_units = 2'd1;
            pend_d      = 1'b1;
          end else if (is_low) begin
            err_d = utd_pkg::ST_UNPAIRED;
          end else begin
            rec.unit0   = unit16;
            rec.n_units = 2'd1;
          end
        end
      end

      if (end_of_buffer_i) begin
        st = err_d;
        if (enc_q == utd_pkg::ENC_UTF16LE) begin
          if (par_d) begin
            st = utd_pkg::ST_ODD_LEN;
          end else if ((st == utd_pkg::ST_OK) && !done_d && pend_d) begin
            st = utd_pkg::ST_UNPAIRED;
          end
        end else if ((st == utd_pkg::ST_OK) && !done_d && (rem_d != 2'd0)) begin
          st = utd_pkg::ST_TRUNCATED;
        end
        rec.is_eob = 1'b1;
        rec.status = st;
        done_d = 1'b0;
        err_d  = '0;
        rem_d  = '0;
        len_d  = '0;
        acc_d  = '0;
        par_d  = 1'b0;
        held_d = '0;
        pend_d = 1'b0;
      end
    end
  end

  assign push_o = take_i && ((rec.n_units != 2'd0) || rec.is_eob);
  assign rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q  <= utd_pkg::ENC_UTF8;
      done_q <= 1'b0;
      err_q  <= '0;
      rem_q  <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      par_q  <= 1'b0;
      held_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enc_q <= cfg_wdata_i;
      end
      done_q <= done_d;
      err_q  <= err_d;
      rem_q  <= rem_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      par_q  <= par_d;
      held_q <= held_d;
      pend_q <= pend_d;
    end
  end

endmodule

@@ rtl/utd_fifo.sv @@
`timescale 1ns / 1ps

module utd_fifo #(
  parameter int unsigned Depth = utd_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utd_pkg::rec_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output utd_pkg::rec_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  utd_pkg::rec_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/utd_back.sv @@
`timescale 1ns / 1ps

module utd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  utd_pkg::rec_t head_i,
  output logic          pop_o,
  utd_out_if.source     out_if
);

  logic          cur_vld_q, cur_vld_d;
  utd_pkg::rec_t cur_q, cur_d;
  logic [1:0]    idx_q, idx_d;
  logic          out_vld_q, out_vld_d;
  logic [15:0]   unit_q, unit_d;
  logic          uvld_q, uvld_d;
  logic          last_q, last_d;
  logic [2:0]    st_q, st_d;

  logic       out_free;
  logic       cur_take;
  logic [1:0] total_m1;
  logic       cur_last;

  assign out_free = !out_vld_q || out_if.ready;
  assign cur_take = cur_vld_q && out_free;
  assign total_m1 = cur_q.n_units + {1'b0, cur_q.is_eob} - 2'd1;
  assign cur_last = (idx_q == total_m1);
  assign pop_o    = !empty_i && (!cur_vld_q || (cur_take && cur_last));

  always_comb begin
    cur_vld_d = cur_vld_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    unit_d    = unit_q;
    uvld_d    = uvld_q;
    last_d    = last_q;
    st_d      = st_q;
    if (out_if.ready) begin
      out_vld_d = 1'b0;
    end
    if (cur_take) begin
      out_vld_d = 1'b1;
      if (idx_q < cur_q.n_units) begin
        unit_d = (idx_q == 2'd0) ? cur_q.unit0 : cur_q.unit1;
        uvld_d = 1'b1;
        last_d = 1'b0;
        st_d   = utd_pkg::ST_OK;
      end else begin
        unit_d = '0;
        uvld_d = 1'b0;
        last_d = 1'b1;
        st_d   = cur_q.status;
      end
      idx_d = idx_q + 2'd1;
      if (cur_last) begin
        cur_vld_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_vld_d = 1'b1;
      cur_d     = head_i;
      idx_d     = '0;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.code_unit  = unit_q;
  assign out_if.unit_valid = uvld_q;
  assign out_if.last       = last_q;
  assign out_if.status     = st_q;

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    unit_q <= unit_d;
    uvld_q <= uvld_d;
    last_q <= last_d;
    st_q   <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

@@ rtl/null_terminated_text_to_utf16_decoder.sv @@
// Accepts one byte per cycle while the request queue has room.
// Results go from the queue through a record register to the output register.
// The output side gives one result per cycle unless stalled by out_if.ready;
// a byte with k results holds it for all k; the queue absorbs the difference.
// Reset (asynchronous, active low) clears the decoder state, the queue and the
// output valid flag, and selects UTF-8 input.
`timescale 1ns / 1ps

module null_terminated_text_to_utf16_decoder #(
  parameter int unsigned FifoDepth = utd_pkg::FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  utd_in_if.sink    in_if,
  utd_out_if.source out_if
);

  logic          take;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  utd_pkg::rec_t push_rec;
  utd_pkg::rec_t head_rec;

  assign in_if.ready = !full;
  assign take        = in_if.valid && !full;

  utd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .take_i          (take),
    .data_byte_i     (in_if.data_byte),
    .end_of_buffer_i (in_if.end_of_buffer),
    .push_o          (push),
    .rec_o           (push_rec)
  );

  utd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_rec),
    .empty_o     (empty)
  );

  utd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_rec),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

@@ rtl/utd_checker.sv @@
`timescale 1ns / 1ps

module utd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] code_unit_i,
  input logic        unit_valid_i,
  input logic        last_i,
  input logic [2:0]  status_i
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(code_unit_i) && $stable(unit_valid_i) && $stable(last_i) && $stable(status_i))
    else $error("stalled result changed");

  // A unit item never carries status or the end marker.
  a_unit_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unit_valid_i |-> !last_i && (status_i == utd_pkg::ST_OK))
    else $error("unit item carries status");

  // A status item closes the buffer and carries no unit.
  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !unit_valid_i |-> last_i && (code_unit_i == 16'h0000))
    else $error("malformed status item");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i != 3'd7))
    else $error("undefined status code");

endmodule

bind null_terminated_text_to_utf16_decoder utd_checker u_utd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .code_unit_i  (out_if.code_unit),
  .unit_valid_i (out_if.unit_valid),
  .last_i       (out_if.last),
  .status_i     (out_if.status)
);

@@ test/tb_null_terminated_text_to_utf16_decoder.sv @@
`timescale 1ns / 1ps

module tb_null_terminated_text_to_utf16_decoder;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last;
    logic [2:0]  status;
  } unit_item_t;

  class utf16_scoreboard;
    logic         encoding;
    logic         text_done;
    logic [2:0]   err_code;
    logic [1:0]   remaining;
    logic [2:0]   seq_len;
    logic [20:0]  accum;
    logic         parity;
    logic [7:0]   held;
    logic         pend_hi;
    unit_item_t   pending_q[$];
    int unsigned  errors;

    function new();
      encoding = utd_pkg::ENC_UTF8;
      errors = 0;
      clear();
    endfunction

    function void clear();
      text_done = 1'b0;
      err_code = utd_pkg::ST_OK;
      remaining = 2'd0;
      seq_len = 3'd0;
      accum = 21'd0;
      parity = 1'b0;
      held = 8'd0;
      pend_hi = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function void push_item(logic [15:0] u, logic uv, logic lst, logic [2:0] st);
      unit_item_t item;
      item.code_unit = u;
      item.unit_valid = uv;
      item.last = lst;
      item.status = st;
      pending_q = {pending_q, item};
    endfunction

    function void push_code_point(logic [20:0] cp);
      logic [20:0] v;
      if (cp <= 21'hFFFF) begin
        push_item(cp[15:0], 1'b1, 1'b0, utd_pkg::ST_OK);
      end else begin
        v = cp - utd_pkg::CP_SUPP_BASE;
        push_item(utd_pkg::SURR_HI_MIN + {6'd0, v[19:10]}, 1'b1, 1'b0, utd_pkg::ST_OK);
        push_item(utd_pkg::SURR_LO_MIN + {6'd0, v[9:0]}, 1'b1, 1'b0, utd_pkg::ST_OK);
      end
    endfunction

    // A request is noted at the edge where it is accepted.
    function void note_request(logic [7:0] b, logic eob);
      logic        active;
      logic        bad;
      logic        hi;
      logic        lo;
      logic [15:0] u;
      logic [2:0]  st;
      active = !text_done && err_code == utd_pkg::ST_OK;
      if (encoding == utd_pkg::ENC_UTF8) begin
        if (active) begin
          if (remaining == 2'd0) begin
            if (b == 8'h00) begin
              text_done = 1'b1;
            end else if (!b[7]) begin
              push_code_point({13'd0, b});
            end else if (b[7:5] == 3'b110) begin
              seq_len = 3'd2;
              remaining = 2'd1;
              accum = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
              seq_len = 3'd3;
              remaining = 2'd2;
              accum = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
              seq_len = 3'd4;
              remaining = 2'd3;
              accum = {18'd0, b[2:0]};
            end else begin
              err_code = utd_pkg::ST_BAD_LEAD;
            end
          end else if (b[7:6] != 2'b10) begin
            err_code = utd_pkg::ST_BAD_CONT;
          end else begin
            accum = {accum[14:0], b[5:0]};
            remaining = remaining - 2'd1;
            if (remaining == 2'd0) begin
              bad = (seq_len == 3'd2 && accum < 21'h80) ||
                    (seq_len == 3'd3 && accum < 21'h800) ||
                    (seq_len == 3'd4 && accum < utd_pkg::CP_SUPP_BASE) ||
                    accum > utd_pkg::CP_MAX ||
                    (accum >= {5'd0, utd_pkg::SURR_HI_MIN} &&
                     accum <= {5'd0, utd_pkg::SURR_LO_MAX});
              if (bad) begin
                err_code = utd_pkg::ST_RANGE;
              end else begin
                push_code_point(accum);
              end
              accum = 21'd0;
              seq_len = 3'd0;
            end
          end
        end
      end else if (!parity) begin
        held = b;
        parity = 1'b1;
      end else begin
        parity = 1'b0;
        u = {b, held};
        hi = u >= utd_pkg::SURR_HI_MIN && u <= utd_pkg::SURR_HI_MAX;
        lo = u >= utd_pkg::SURR_LO_MIN && u <= utd_pkg::SURR_LO_MAX;
        if (active) begin
          if (pend_hi) begin
            if (lo) begin
              push_item(u, 1'b1, 1'b0, utd_pkg::ST_OK);
              pend_hi = 1'b0;
            end else begin
              err_code = utd_pkg::ST_UNPAIRED;
            end
          end else if (u == 16'h0000) begin
            text_done = 1'b1;
          end else if (hi) begin
            push_item(u, 1'b1, 1'b0, utd_pkg::ST_OK);
            pend_hi = 1'b1;
          end else if (lo) begin
            err_code = utd_pkg::ST_UNPAIRED;
          end else begin
            push_item(u, 1'b1, 1'b0, utd_pkg::ST_OK);
          end
        end
      end
      if (eob) begin
        st = err_code;
        if (encoding == utd_pkg::ENC_UTF16LE) begin
          if (parity) begin
            st = utd_pkg::ST_ODD_LEN;
          end else if (st == utd_pkg::ST_OK && !text_done && pend_hi) begin
            st = utd_pkg::ST_UNPAIRED;
          end
        end else if (st == utd_pkg::ST_OK && !text_done && remaining != 2'd0) begin
          st = utd_pkg::ST_TRUNCATED;
        end
        push_item(16'h0000, 1'b0, 1'b1, st);
        clear();
      end
    endfunction

    task check_result(logic [15:0] u, logic uv, logic lst, logic [2:0] st);
      unit_item_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result: code_unit %h unit_valid %b last %b status %0d",
                         u, uv, lst, st));
        return;
      end
      want = pending_q.pop_front();
      if (u !== want.code_unit || uv !== want.unit_valid || lst !== want.last ||
          st !== want.status) begin
        report($sformatf({"got/want: code_unit %h/%h unit_valid %b/%b last %b/%b ",
                          "status %0d/%0d"}, u, want.code_unit, uv, want.unit_valid,
                         lst, want.last, st, want.status));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  utd_in_if  req_if ();
  utd_out_if unit_if ();

  null_terminated_text_to_utf16_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (req_if),
    .out_if     (unit_if)
  );

  utf16_scoreboard sb;
  logic [7:0]      text_q[$];
  bit              sender_gaps;
  int unsigned     burst_left;
  int unsigned     stall_mode;
  bit              hold_req;
  int unsigned     cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned tick;
    int unsigned hold_left;
    unit_if.ready = 1'b0;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        unit_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          1: unit_if.ready <= ($urandom_range(0, 3) != 0);
          2: unit_if.ready <= ($urandom_range(0, 1) != 0);
          3: unit_if.ready <= ((tick % 7) < 3);
          default: unit_if.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (unit_if.valid && unit_if.ready) begin
      sb.check_result(unit_if.code_unit, unit_if.unit_valid, unit_if.last, unit_if.status);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left != 0) burst_left--;
    req_if.valid <= 1'b1;
    req_if.data_byte <= b;
    req_if.end_of_buffer <= eob;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(b, eob);
  endtask

  task automatic send_text(input bit with_eob);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], with_eob && i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_encoding(input logic enc);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= enc;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.encoding = enc;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void push_utf8(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_unit16(input logic [15:0] u);
    add_byte(u[7:0]);
    add_byte(u[15:8]);
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] u;
    u = 16'($urandom_range(1, 'hFFFF));
    if (u >= utd_pkg::SURR_HI_MIN && u <= utd_pkg::SURR_LO_MAX) u = u ^ 16'h2000;
    return u;
  endfunction

  function automatic void build_utf8_text();
    int unsigned n;
    int unsigned r;
    int          len;
    logic [20:0] cp;
    n = $urandom_range(1, 4);
    repeat (n) begin
      r = $urandom_range(0, 31);
      if (r < 10) begin
        push_utf8(21'($urandom_range(1, 'h7F)), 1);
      end else if (r < 15) begin
        push_utf8(21'($urandom_range('h80, 'h7FF)), 2);
      end else if (r < 21) begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
        push_utf8(cp, 3);
      end else if (r < 26) begin
        push_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
      end else if (r == 26) begin
        len = $urandom_range(2, 4);
        cp = 21'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
        push_utf8(cp, len);
      end else if (r == 27) begin
        if ($urandom_range(0, 1) != 0) begin
          push_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
        end else begin
          push_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end
      end else if (r == 28) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (r == 29) begin
        add_byte(8'h00);
      end else if (r == 30) begin
        push_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
        void'(text_q.pop_back());
      end else begin
        add_byte(8'($urandom_range('h80, 'hBF)));
      end
    end
  endfunction

  function automatic void build_utf16_text();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(1, 4);
    repeat (n) begin
      r = $urandom_range(0, 31);
      if (r < 16) begin
        push_unit16(rand_bmp());
      end else if (r < 24) begin
        push_unit16(16'($urandom_range('hD800, 'hDBFF)));
        push_unit16(16'($urandom_range('hDC00, 'hDFFF)));
      end else if (r == 24) begin
        push_unit16(16'($urandom_range('hD800, 'hDBFF)));
      end else if (r == 25) begin
        push_unit16(16'($urandom_range('hDC00, 'hDFFF)));
      end else if (r == 26) begin
        push_unit16(16'($urandom_range('hD800, 'hDBFF)));
        push_unit16(rand_bmp());
      end else if (r == 27) begin
        push_unit16(16'($urandom_range(0, 'hFFFF)));
      end else if (r == 28) begin
        push_unit16(16'h0000);
      end else if (r == 29) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        push_unit16(($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001);
      end
    end
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned phase;
    logic        enc;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_if.valid = 1'b0;
    req_if.data_byte = 8'h00;
    req_if.end_of_buffer = 1'b0;
    sender_gaps = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_encoding(utd_pkg::ENC_UTF8);
    text_q = {8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F};
    send_text(1'b1);
    text_q = {8'hE2, 8'h82};
    send_text(1'b1);
    text_q = {8'hC3, 8'h00};
    send_text(1'b1);
    text_q = {8'h00, 8'hFF};
    send_text(1'b1);
    text_q = {8'h41};
    send_text(1'b0);
    write_encoding(utd_pkg::ENC_UTF16LE);
    text_q = {8'h3D, 8'hD8, 8'h00, 8'hDE};
    send_text(1'b1);
    text_q = {8'h3D, 8'hD8, 8'h41, 8'h00};
    send_text(1'b1);
    text_q = {8'h00, 8'hDC};
    send_text(1'b1);
    text_q = {8'h3D, 8'hD8};
    send_text(1'b1);
    text_q = {8'h00, 8'h00, 8'h41};
    send_text(1'b1);

    random_sent = 0;
    phase = 0;
    while (random_sent < 75) begin
      enc = (phase < 2) ? phase[0] : logic'($urandom_range(0, 1));
      write_encoding(enc);
      stall_mode = phase % 4;
      sender_gaps = (phase % 3) != 0;
      burst_left = 0;
      if (phase == 1) hold_req = 1'b1;
      repeat ((phase == 1) ? 8 : 3) begin
        if (enc == utd_pkg::ENC_UTF8) begin
          build_utf8_text();
        end else begin
          build_utf16_text();
        end
        random_sent += text_q.size();
        send_text(1'b1);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
